// ===== sv/rpd_pkg.sv =====
package rpd_pkg;

  // Input mode codes
  localparam logic [1:0] MODE_RISE = 2'd0;
  localparam logic [1:0] MODE_FALL = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // Configuration register map
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic REG_TICKS_PER_US = 1'b0;
  localparam logic REG_TIMEOUT_US   = 1'b1;

  localparam logic [7:0]  TICKS_PER_US_RST = 8'd80;
  localparam logic [23:0] TIMEOUT_US_RST   = 24'd250000;

  // Pulse window and neutral point in microseconds
  localparam logic [31:0] WIDTH_LO  = 32'd900;
  localparam logic [31:0] WIDTH_HI  = 32'd2100;
  localparam logic [31:0] WIDTH_MID = 32'd1500;
  localparam logic [10:0] PULSE_MID = 11'd1500;

  // Reciprocals: x/500 = (x*RECIP_500) >> 26 for x < 2^17,
  // x/127 = (x*RECIP_127) >> 23 for x <= 64000
  localparam logic [17:0] RECIP_500 = 18'd134218;
  localparam int unsigned SHIFT_500 = 26;
  localparam logic [16:0] RECIP_127 = 17'd66053;
  localparam int unsigned SHIFT_127 = 23;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    OP_RISE,
    OP_FALL,
    OP_TICK,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] cap;
    logic [63:0] now;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  ticks_per_us;
    logic [23:0] timeout_us;
  } cfg_t;

endpackage

// ===== sv/rpd_if.sv =====
interface rpd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] capture_ticks;
  logic [63:0] now_us;

  modport source (output valid, mode, capture_ticks, now_us, input ready);
  modport sink (input valid, mode, capture_ticks, now_us, output ready);
endinterface

interface rpd_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] position;
  logic [10:0]       output_pulse_us;
  logic              timed_out;
  logic              timeout_began;
  logic              pulse_accepted;

  modport source (output valid, position, output_pulse_us, timed_out, timeout_began,
                  pulse_accepted, input ready);
  modport sink (input valid, position, output_pulse_us, timed_out, timeout_began,
                pulse_accepted, output ready);
endinterface

// ===== sv/rc_pwm_pulse_decoder.sv =====
// Flow: a rising edge, update tick, unused mode or zero-divisor falling edge is answered in
//   the idle state; an accepted falling edge runs the bit-serial restoring divide, window
//   check and three scaling steps (scale, clamp, width); a rejected one skips the scaling.
// The back end takes one request at a time, only when idle and its result register is free.
// Reset (async, active low): ticks_per_us 80, timeout 250000 us, queue empty, decoder state
//   zero but for the held and shown pulse width, which resets to 1500 us.
module rc_pwm_pulse_decoder #(
  parameter int unsigned QueueDepth = rpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rpd_in_if.sink                     in_i,
  rpd_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rpd_pkg::APB_AW-1:0] paddr,
  input  logic [rpd_pkg::APB_DW-1:0] pwdata,
  output logic [rpd_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import rpd_pkg::*;

  cfg_t cfg_q;
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // Configuration registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEOUT_US) ? {8'd0, cfg_q.timeout_us}
                                               : {24'd0, cfg_q.ticks_per_us};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_us <= TICKS_PER_US_RST;
      cfg_q.timeout_us   <= TIMEOUT_US_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_TICKS_PER_US) begin
        cfg_q.ticks_per_us <= pwdata[7:0];
      end else begin
        cfg_q.timeout_us <= pwdata[23:0];
      end
    end
  end

  rpd_front u_front (
    .clk_i,
    .rst_ni,
    .in_i,
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  rpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  rpd_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_o
  );

endmodule

// ===== sv/rpd_front.sv =====
module rpd_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  rpd_in_if.sink       in_i,
  output logic         push_valid_o,
  input  logic         push_ready_i,
  output rpd_pkg::cmd_t push_cmd_o
);
  import rpd_pkg::*;

  logic valid_q;
  cmd_t cmd_q;
  op_e  op;

  // Classify the request by its mode
  always_comb begin
    case (in_i.mode)
      MODE_RISE: op = OP_RISE;
      MODE_FALL: op = OP_FALL;
      MODE_TICK: op = OP_TICK;
      default:   op = OP_NOP;
    endcase
  end

  assign in_i.ready   = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;
  assign push_cmd_o   = cmd_q;

  // Hold the classified request until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q <= '{op: op, cap: in_i.capture_ticks, now: in_i.now_us};
    end
  end

endmodule

// ===== sv/rpd_queue.sv =====
module rpd_queue #(
  parameter int unsigned Depth = rpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  rpd_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output rpd_pkg::cmd_t pop_cmd_o
);
  import rpd_pkg::*;

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  cmd_t            mem_q [Depth];
  logic [IdxW-1:0] wr_ptr_q;
  logic [IdxW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push;
  logic            pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== sv/rpd_back.sv =====
module rpd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rpd_pkg::cfg_t cfg_i,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  rpd_pkg::cmd_t pop_cmd_i,
  rpd_out_if.source     out_o
);
  import rpd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_SCALE,
    S_CLAMP,
    S_WIDTH,
    S_FIN
  } state_e;

  state_e            state_q;
  logic [31:0]       start_q;
  logic signed [7:0] pos_q;
  logic [63:0]       ptime_q;
  logic              lost_q;
  logic [10:0]       opulse_q;
  logic [31:0]       cap_q;
  logic [63:0]       now_q;
  logic [7:0]        rem_q;
  logic [31:0]       quo_q;
  logic [4:0]        cnt_q;
  logic              neg_q;
  logic              acc_q;
  logic [16:0]       x_q;
  logic [34:0]       prod_q;
  logic [15:0]       wx_q;
  logic [32:0]       wprod_q;

  logic              out_valid_q;
  logic signed [7:0] out_pos_q;
  logic [10:0]       out_pulse_q;
  logic              out_lost_q;
  logic              out_began_q;
  logic              out_acc_q;

  logic        out_free;
  logic        pop;
  logic [63:0] elapsed;
  logic        expired;
  logic [8:0]  div_r;
  logic        div_ge;
  logic [7:0]  div_rem;
  logic        width_ok;
  logic [9:0]  dev;
  logic [8:0]  scale_q9;
  logic [7:0]  mag;
  logic [16:0] mag500;
  logic [8:0]  back_q9;

  assign out_free    = !out_valid_q || out_o.ready;
  assign pop_ready_o = (state_q == S_IDLE) && out_free;
  assign pop         = pop_valid_i && pop_ready_o;

  assign out_o.valid           = out_valid_q;
  assign out_o.position        = out_pos_q;
  assign out_o.output_pulse_us = out_pulse_q;
  assign out_o.timed_out       = out_lost_q;
  assign out_o.timeout_began   = out_began_q;
  assign out_o.pulse_accepted  = out_acc_q;

  // Timeout test on an update tick
  assign elapsed = pop_cmd_i.now - ptime_q;
  assign expired = elapsed > {40'd0, cfg_i.timeout_us};

  // One restoring divide step per cycle
  assign div_r   = {rem_q, quo_q[31]};
  assign div_ge  = div_r >= {1'b0, cfg_i.ticks_per_us};
  assign div_rem = div_ge ? 8'(div_r - {1'b0, cfg_i.ticks_per_us}) : div_r[7:0];

  // Window check and distance from neutral
  assign width_ok = (quo_q >= WIDTH_LO) && (quo_q <= WIDTH_HI);
  assign dev      = (quo_q >= WIDTH_MID) ? 10'(quo_q - WIDTH_MID) : 10'(WIDTH_MID - quo_q);

  // Clamp the scaled magnitude and map it back to microseconds
  assign scale_q9 = prod_q[SHIFT_500+8:SHIFT_500];
  always_comb begin
    if (neg_q) begin
      mag = (scale_q9 > 9'd128) ? 8'd128 : scale_q9[7:0];
    end else begin
      mag = (scale_q9 > 9'd127) ? 8'd127 : scale_q9[7:0];
    end
  end
  assign mag500  = {mag, 9'd0} - {6'd0, mag, 3'd0} - {7'd0, mag, 2'd0};
  assign back_q9 = wprod_q[SHIFT_127+8:SHIFT_127];

  // Sequencer, decoder state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= '0;
      pos_q       <= '0;
      ptime_q     <= '0;
      lost_q      <= 1'b0;
      opulse_q    <= PULSE_MID;
      out_valid_q <= 1'b0;
      out_pos_q   <= '0;
      out_pulse_q <= PULSE_MID;
      out_lost_q  <= 1'b0;
      out_began_q <= 1'b0;
      out_acc_q   <= 1'b0;
      cap_q       <= '0;
      now_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      acc_q       <= 1'b0;
      x_q         <= '0;
      prod_q      <= '0;
      wx_q        <= '0;
      wprod_q     <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop) begin
            out_pos_q   <= pos_q;
            out_pulse_q <= opulse_q;
            out_lost_q  <= lost_q;
            out_began_q <= 1'b0;
            out_acc_q   <= 1'b0;
            case (pop_cmd_i.op)
              OP_RISE: begin
                start_q     <= pop_cmd_i.cap;
                out_valid_q <= 1'b1;
              end
              OP_FALL: begin
                if (cfg_i.ticks_per_us == '0) begin
                  start_q     <= pop_cmd_i.cap;
                  out_valid_q <= 1'b1;
                end else begin
                  cap_q   <= pop_cmd_i.cap;
                  now_q   <= pop_cmd_i.now;
                  rem_q   <= '0;
                  quo_q   <= pop_cmd_i.cap - start_q;
                  cnt_q   <= '0;
                  state_q <= S_DIV;
                end
              end
              OP_TICK: begin
                if (expired) begin
                  pos_q       <= '0;
                  ptime_q     <= pop_cmd_i.now;
                  lost_q      <= 1'b1;
                  opulse_q    <= PULSE_MID;
                  out_pos_q   <= '0;
                  out_pulse_q <= PULSE_MID;
                  out_lost_q  <= 1'b1;
                  out_began_q <= !lost_q;
                end
                out_valid_q <= 1'b1;
              end
              default: begin
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        S_DIV: begin
          rem_q <= div_rem;
          quo_q <= {quo_q[30:0], div_ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'd31) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          acc_q <= width_ok;
          neg_q <= quo_q < WIDTH_MID;
          x_q   <= {dev, 7'd0} - {7'd0, dev};
          if (width_ok) begin
            state_q <= S_SCALE;
          end else begin
            start_q <= cap_q;
            state_q <= S_FIN;
          end
        end
        S_SCALE: begin
          prod_q  <= 35'(x_q * RECIP_500);
          state_q <= S_CLAMP;
        end
        S_CLAMP: begin
          pos_q   <= neg_q ? $signed(8'(-mag)) : $signed(mag);
          ptime_q <= now_q;
          lost_q  <= 1'b0;
          wx_q    <= mag500[15:0];
          state_q <= S_WIDTH;
        end
        S_WIDTH: begin
          wprod_q <= 33'(wx_q * RECIP_127);
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_pos_q   <= pos_q;
            out_lost_q  <= lost_q;
            out_began_q <= 1'b0;
            out_acc_q   <= acc_q;
            out_valid_q <= 1'b1;
            if (acc_q) begin
              opulse_q    <= neg_q ? PULSE_MID - {2'd0, back_q9} : PULSE_MID + {2'd0, back_q9};
              out_pulse_q <= neg_q ? PULSE_MID - {2'd0, back_q9} : PULSE_MID + {2'd0, back_q9};
            end else begin
              out_pulse_q <= opulse_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/rpd_checker.sv =====
module rpd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic signed [7:0] out_position_i,
  input logic [10:0]       out_pulse_us_i,
  input logic              out_timed_out_i,
  input logic              out_began_i,
  input logic              out_accepted_i
);

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Lost signal means neutral position and neutral pulse
  a_lost_neutral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_timed_out_i |-> out_position_i == 8'sd0 && out_pulse_us_i == 11'd1500)
    else $error("lost signal without neutral output");

  // Entering timeout implies the lost flag, never together with an accepted pulse
  a_began_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_began_i |-> out_timed_out_i && !out_accepted_i)
    else $error("timeout start without lost flag");

  // An accepted pulse clears the lost flag and gives a pulse inside the servo range
  a_accept_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_accepted_i |-> !out_timed_out_i && out_pulse_us_i >= 11'd997 &&
                                      out_pulse_us_i <= 11'd2003)
    else $error("accepted pulse with bad state");

endmodule

bind rc_pwm_pulse_decoder rpd_checker u_rpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_position_i  (out_o.position),
  .out_pulse_us_i  (out_o.output_pulse_us),
  .out_timed_out_i (out_o.timed_out),
  .out_began_i     (out_o.timeout_began),
  .out_accepted_i  (out_o.pulse_accepted)
);
